FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked property that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/qrs_pkg.sv
package qrs_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_REPEATED = 2'd0;
    localparam logic [1:0] KIND_DISTINCT = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;
    localparam logic [1:0] KIND_A_ZERO   = 2'd3;

    // square root of {|D|, 16 zero bits}
    localparam int RAD_W    = 50;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int REM_W    = 29;
    // |N| * 2^8 over |2a|
    localparam int DIVD_W   = 34;
    localparam int DIVS_W   = 17;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
    } t_in;

    typedef struct packed {
        logic        [1:0]  root_kind;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [31:0] bb;
        logic signed [31:0] ac;
    } t_prod;

endpackage

FILE: rtl/core/qrs_front.sv
module qrs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  qrs_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_q_full,
    output qrs_pkg::t_prod o_prod
);
    import qrs_pkg::*;

    logic  r_valid;
    t_prod r_prod;
    logic  w_adv;

    assign w_adv   = !r_valid || !i_q_full;
    assign o_full  = !w_adv;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_push) begin
            r_prod.a  <= i_item.coef_a;
            r_prod.b  <= i_item.coef_b;
            r_prod.bb <= 32'(i_item.coef_b) * 32'(i_item.coef_b);
            r_prod.ac <= 32'(i_item.coef_a) * 32'(i_item.coef_c);
        end
    end

endmodule

FILE: rtl/core/qrs_fifo.sv
module qrs_fifo #(
    parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  qrs_pkg::t_prod i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output qrs_pkg::t_prod o_rdata,
    output logic           o_empty
);
    import qrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_prod          r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: rtl/core/qrs_div_pipe.sv
module qrs_div_pipe #(
    parameter int NW = qrs_pkg::DIVD_W,
    parameter int DW = qrs_pkg::DIVS_W
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quot
);
    // word shifts dividend bits out at the top and quotient bits in at the bottom
    logic [NW-1:0] r_word [1:NW];
    logic [DW-1:0] r_rem  [1:NW];
    logic [DW-1:0] r_dvs  [1:NW];

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [NW-1:0] w_word;
        logic [DW-1:0] w_rem;
        logic [DW-1:0] w_dvs;
        logic [DW:0]   w_tmp;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_word = i_dividend;
            assign w_rem  = '0;
            assign w_dvs  = i_divisor;
        end else begin : g_next
            assign w_word = r_word[k];
            assign w_rem  = r_rem[k];
            assign w_dvs  = r_dvs[k];
        end

        assign w_tmp = {w_rem, w_word[NW-1]};
        assign w_ge  = (w_tmp >= {1'b0, w_dvs});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? DW'(w_tmp - {1'b0, w_dvs}) : w_tmp[DW-1:0];
                r_word[k+1] <= {w_word[NW-2:0], w_ge};
                r_dvs[k+1]  <= w_dvs;
            end
        end
    end

    assign o_quot = r_word[NW];

endmodule

FILE: rtl/core/qrs_back.sv
module qrs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    output logic           o_q_rd,
    input  qrs_pkg::t_prod i_prod,
    output logic           o_empty,
    input  logic           i_pop,
    output qrs_pkg::t_out  o_result
);
    import qrs_pkg::*;

    localparam int RT_W = SQ_STEPS;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [24:0] nb;
        logic              a_neg;
        logic [DIVS_W-1:0] den;
    } t_side;

    typedef struct packed {
        logic [1:0] kind;
        logic       neg1;
        logic       neg2;
    } t_tail;

    logic w_en;
    logic r_out_valid;
    t_out r_out;

    assign w_en     = !r_out_valid || i_pop;
    assign o_q_rd   = w_en && !i_q_empty;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // discriminant and classification
    logic signed [34:0] w_disc;
    logic        [34:0] w_mag;
    logic        [1:0]  w_kind;
    logic signed [16:0] w_den;

    assign w_disc = 35'(i_prod.bb) - (35'(i_prod.ac) <<< 2);
    assign w_mag  = w_disc[34] ? 35'(-w_disc) : 35'(w_disc);
    assign w_den  = 17'(i_prod.a) <<< 1;

    always_comb begin
        if (i_prod.a == '0) begin
            w_kind = KIND_A_ZERO;
        end else if (w_disc == '0) begin
            w_kind = KIND_REPEATED;
        end else if (w_disc[34]) begin
            w_kind = KIND_COMPLEX;
        end else begin
            w_kind = KIND_DISTINCT;
        end
    end

    logic             r_sq_vld  [SQ_STEPS+1];
    t_side            r_sq_side [SQ_STEPS+1];
    logic [RAD_W-1:0] r_sq_rad  [SQ_STEPS+1];
    logic [REM_W-1:0] r_sq_rem  [SQ_STEPS+1];
    logic [RT_W-1:0]  r_sq_root [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= o_q_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0].kind  <= w_kind;
            r_sq_side[0].nb    <= -(25'(i_prod.b) <<< 8);
            r_sq_side[0].a_neg <= i_prod.a[15];
            r_sq_side[0].den   <= w_den[16] ? DIVS_W'(-w_den) : DIVS_W'(w_den);
            r_sq_rad[0]        <= {1'b0, w_mag[32:0], 16'b0};
            r_sq_rem[0]        <= '0;
            r_sq_root[0]       <= '0;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [REM_W-1:0] w_tmp;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;
        assign w_tmp   = {r_sq_rem[k][REM_W-3:0], r_sq_rad[k][RAD_W-1 -: 2]};
        assign w_trial = REM_W'({r_sq_root[k], 2'b01});
        assign w_ge    = (w_tmp >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_rad[k+1]  <= {r_sq_rad[k][RAD_W-3:0], 2'b00};
                r_sq_rem[k+1]  <= w_ge ? (w_tmp - w_trial) : w_tmp;
                r_sq_root[k+1] <= {r_sq_root[k][RT_W-2:0], w_ge};
            end
        end
    end

    // numerators
    t_side              w_ls;
    logic signed [26:0] w_s;
    logic signed [26:0] w_n1;
    logic signed [26:0] w_n2;
    logic        [26:0] w_m1;
    logic        [26:0] w_m2;

    assign w_ls = r_sq_side[SQ_STEPS];
    assign w_s  = 27'(r_sq_root[SQ_STEPS]);

    always_comb begin
        if (w_ls.kind == KIND_COMPLEX) begin
            w_n1 = 27'(w_ls.nb);
            w_n2 = w_s;
        end else begin
            w_n1 = 27'(w_ls.nb) + w_s;
            w_n2 = 27'(w_ls.nb) - w_s;
        end
    end

    assign w_m1 = w_n1[26] ? 27'(-w_n1) : 27'(w_n1);
    assign w_m2 = w_n2[26] ? 27'(-w_n2) : 27'(w_n2);

    logic              r_dv_vld  [DIVD_W+1];
    t_tail             r_dv_tail [DIVD_W+1];
    logic [DIVD_W-1:0] r_nm_d1;
    logic [DIVD_W-1:0] r_nm_d2;
    logic [DIVS_W-1:0] r_nm_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_sq_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_tail[0].kind <= w_ls.kind;
            r_dv_tail[0].neg1 <= w_n1[26] ^ w_ls.a_neg;
            r_dv_tail[0].neg2 <= w_n2[26] ^ w_ls.a_neg;
            r_nm_d1           <= {w_m1[25:0], 8'b0};
            r_nm_d2           <= {w_m2[25:0], 8'b0};
            r_nm_den          <= w_ls.den;
        end
    end

    for (genvar k = 0; k < DIVD_W; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_tail[k+1] <= r_dv_tail[k];
            end
        end
    end

    logic [DIVD_W-1:0] w_q1;
    logic [DIVD_W-1:0] w_q2;

    qrs_div_pipe #(.NW(DIVD_W), .DW(DIVS_W)) u_div1 (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_nm_d1),
        .i_divisor  (r_nm_den),
        .o_quot     (w_q1)
    );

    qrs_div_pipe #(.NW(DIVD_W), .DW(DIVS_W)) u_div2 (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_nm_d2),
        .i_divisor  (r_nm_den),
        .o_quot     (w_q2)
    );

    // apply sign, clip to 32 bits
    function automatic logic [32:0] clip(input logic [DIVD_W-1:0] q, input logic neg);
        logic [DIVD_W-1:0] lim;
        logic              over;
        logic [31:0]       val;
        lim  = neg ? DIVD_W'(34'h0_8000_0000) : DIVD_W'(34'h0_7FFF_FFFF);
        over = (q > lim);
        if (over) begin
            val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            val = neg ? 32'(-q[31:0]) : q[31:0];
        end
        return {over, val};
    endfunction

    t_tail       w_lt;
    logic [32:0] w_c1;
    logic [32:0] w_c2;

    assign w_lt = r_dv_tail[DIVD_W];
    assign w_c1 = clip(w_q1, w_lt.neg1);
    assign w_c2 = clip(w_q2, w_lt.neg2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_vld[DIVD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.root_kind <= w_lt.kind;
            if (w_lt.kind == KIND_A_ZERO) begin
                r_out.first_value  <= '0;
                r_out.second_value <= '0;
                r_out.saturated    <= 1'b0;
            end else begin
                r_out.first_value  <= w_c1[31:0];
                r_out.second_value <= w_c2[31:0];
                r_out.saturated    <= w_c1[32] | w_c2[32];
            end
        end
    end

endmodule

FILE: rtl/core/quadratic_root_solver_top.sv
// Path: front register, queue (behind older items), discriminant register, square root
// stages, numerator register, divider stages and output register. Throughput: one item
// per cycle; set by the bit-per-stage root and divider pipelines. A stall at the output
// halts the back pipeline; the queue lets the front keep taking. Reset (i_rst_n low,
// synchronous) empties the queue and all pipeline valids.
module quadratic_root_solver_top #(
    parameter int QUEUE_DEPTH = qrs_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  qrs_pkg::t_in  i_item,
    output logic          o_empty,
    input  logic          i_pop,
    output qrs_pkg::t_out o_result
);
    import qrs_pkg::*;

    `include "assert_macros.svh"

    logic  w_f_valid;
    logic  w_q_full;
    logic  w_q_empty;
    logic  w_q_rd;
    t_prod w_f_prod;
    t_prod w_q_prod;

    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_valid  (w_f_valid),
        .i_q_full (w_q_full),
        .o_prod   (w_f_prod)
    );

    qrs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_f_valid),
        .i_wdata (w_f_prod),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_prod),
        .o_empty (w_q_empty)
    );

    qrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .o_q_rd    (w_q_rd),
        .i_prod    (w_q_prod),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

    `ASSERT_IMPLY(a_zero_clear, i_clk, i_rst_n, !o_empty && o_result.root_kind == KIND_A_ZERO, o_result.first_value == '0 && o_result.second_value == '0 && !o_result.saturated, "a equal to zero must give cleared results")
    `ASSERT_IMPLY(a_repeated_equal, i_clk, i_rst_n, !o_empty && o_result.root_kind == KIND_REPEATED, o_result.first_value == o_result.second_value, "repeated root must give equal values")
    `ASSERT_IMPLY(a_full_front, i_clk, i_rst_n, o_full, w_f_valid && w_q_full, "full only while front holds and queue is full")
    `ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n |=> o_empty), "result must be empty after reset")

endmodule

FILE: tb/sv/quadratic_root_solver_top_test.sv
module quadratic_root_solver_top_test;
    import qrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic  clk;
    logic  rst_n;
    logic  push;
    logic  full;
    t_in   item;
    logic  empty;
    logic  pop;
    t_out  result;

    t_in   pending_coefs[$];
    t_out  expected_roots[$];
    int    n_errors = 0;
    bit    hold_push = 0;
    bit    in_taken = 0;
    int    push_gap = 0;
    int    pop_gap = 0;

    quadratic_root_solver_top i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (item),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (result)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint scale_div(longint num, longint den, ref bit clipped);
        longint q;
        q = (num * 256) / den;
        if (q > 64'sd2147483647) begin
            clipped = 1'b1;
            q = 64'sd2147483647;
        end else if (q < -64'sd2147483648) begin
            clipped = 1'b1;
            q = -64'sd2147483648;
        end
        return q;
    endfunction

    function automatic t_out solve_roots(t_in c);
        t_out   r;
        longint a, b, k, disc, den, nb, s;
        bit     clipped;
        a = c.coef_a;
        b = c.coef_b;
        k = c.coef_c;
        clipped = 1'b0;
        r = '0;
        if (a == 0) begin
            r.root_kind = KIND_A_ZERO;
            return r;
        end
        disc = b * b - 4 * a * k;
        den = 2 * a;
        nb = -b * 256;
        s = longint'(floor_sqrt(longint'(disc < 0 ? -disc : disc) << 16));
        if (disc >= 0) begin
            r.root_kind = (disc == 0) ? KIND_REPEATED : KIND_DISTINCT;
            r.first_value = 32'(scale_div(nb + s, den, clipped));
            r.second_value = 32'(scale_div(nb - s, den, clipped));
        end else begin
            r.root_kind = KIND_COMPLEX;
            r.first_value = 32'(scale_div(nb, den, clipped));
            r.second_value = 32'(scale_div(s, den, clipped));
        end
        r.saturated = clipped;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            3: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // driver: present words at the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (in_taken) begin
                in_taken = 1'b0;
                void'(pending_coefs.pop_front());
                push_gap = pick_gap();
                if (push_gap > 0) begin
                    push_gap--;
                    push <= 1'b0;
                end else if (pending_coefs.size() > 0 && !hold_push) begin
                    push <= 1'b1;
                    item <= pending_coefs[0];
                end else begin
                    push <= 1'b0;
                end
            end else if (push) begin
                // hold the waiting word
            end else if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (pending_coefs.size() > 0 && !hold_push) begin
                push <= 1'b1;
                item <= pending_coefs[0];
            end else begin
                push <= 1'b0;
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                pop_gap = pick_gap();
            end
        end
    end

    // monitor: predict on accepted inputs, check accepted results
    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full) begin
                expected_roots.push_back(solve_roots(item));
                in_taken = 1'b1;
            end
            if (pop && !empty) begin
                if (expected_roots.size() == 0) begin
                    $error("unexpected result word %p", result);
                    n_errors++;
                end else begin
                    t_out e;
                    e = expected_roots.pop_front();
                    if (result.root_kind !== e.root_kind) begin
                        $error("root_kind exp %0d got %0d", e.root_kind, result.root_kind);
                        n_errors++;
                    end
                    if (result.first_value !== e.first_value) begin
                        $error("first_value exp %0d got %0d", e.first_value,
                               result.first_value);
                        n_errors++;
                    end
                    if (result.second_value !== e.second_value) begin
                        $error("second_value exp %0d got %0d", e.second_value,
                               result.second_value);
                        n_errors++;
                    end
                    if (result.saturated !== e.saturated) begin
                        $error("saturated exp %0d got %0d", e.saturated, result.saturated);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic add_coefs(int a, int b, int c);
        t_in t;
        t.coef_a = 16'(a);
        t.coef_b = 16'(b);
        t.coef_c = 16'(c);
        pending_coefs.push_back(t);
    endtask

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        // directed: a zero, repeated, distinct, complex, extremes, saturation
        add_coefs(0, 256, 256);
        add_coefs(0, 0, 0);
        add_coefs(256, 512, 256);
        add_coefs(256, -1024, 1024);
        add_coefs(256, 0, -1024);
        add_coefs(256, 0, 1024);
        add_coefs(-256, 256, 512);
        add_coefs(1, 32767, -32768);
        add_coefs(1, -32768, 32767);
        add_coefs(-32768, -32768, -32768);
        add_coefs(32767, 32767, 32767);
        add_coefs(-32768, 32767, 32767);
        add_coefs(32767, -32768, -32768);
        add_coefs(-1, 0, 32767);
        add_coefs(-1, 0, -32768);
        add_coefs(1, 0, 0);
        add_coefs(-1, 2, -1);
        add_coefs(2, 4, 2);
        add_coefs(32767, 0, 0);
        add_coefs(-32768, 0, 1);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 1030; i++) begin
            if (i == 500) begin
                wait (pending_coefs.size() == 0);
                hold_push = 1'b1;
                wait (expected_roots.size() == 0);
                @(negedge clk);
                hold_push = 1'b0;
            end
            if ($urandom_range(0, 5) == 0) begin
                int b;
                int a;
                // repeated root: a*c = b*b/4 with b even
                a = $urandom_range(0, 1) ? 1 : -1;
                b = 2 * (int'($urandom_range(0, 362)) - 181);
                add_coefs(a, b, a * (b / 2) * (b / 2));
            end else begin
                t_in t;
                t.coef_a = pick_coef();
                t.coef_b = pick_coef();
                t.coef_c = pick_coef();
                pending_coefs.push_back(t);
            end
        end
        wait (pending_coefs.size() == 0);
        wait (expected_roots.size() == 0);
        repeat (100) @(posedge clk);
        if (n_errors == 0) begin
            $display("[quadratic_root_solver_top] OK");
        end else begin
            $display("[quadratic_root_solver_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[quadratic_root_solver_top] ERROR");
        $finish;
    end

endmodule
